@@ design/gtg_pkg.sv @@
// Shared types, constants and the CORDIC angle table for the go-to-goal controller.
package gtg_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;

    localparam logic [25:0] PI_Q24      = 26'd52707179;
    localparam logic [25:0] HALF_PI_Q24 = 26'd26353589;
    localparam logic [19:0] INVK_Q20    = 20'd636751;

    // register indexes on the configuration port (byte address / 4)
    localparam logic [1:0] REG_RATE_HZ         = 2'd0;
    localparam logic [1:0] REG_ARRIVE_DISTANCE = 2'd1;
    localparam logic [1:0] REG_TURN_THRESHOLD  = 2'd2;
    localparam logic [1:0] REG_SPEED_DIVISOR   = 2'd3;

    typedef struct packed {
        logic               op;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] linear_speed;
        logic signed [31:0] angular_speed;
    } out_item_t;

    // atan(2^-i) in Q24 radians
    function automatic logic [23:0] atan_q24(input logic [5:0] i);
        logic [23:0] r;
        case (i)
            6'd0: r = 24'd13176795;
            6'd1: r = 24'd7778716;
            6'd2: r = 24'd4110060;
            6'd3: r = 24'd2086331;
            6'd4: r = 24'd1047214;
            6'd5: r = 24'd524117;
            6'd6: r = 24'd262123;
            6'd7: r = 24'd131069;
            default: r = (i <= 6'd24) ? (24'd1 << (6'd24 - i)) : 24'd0;
        endcase
        return r;
    endfunction

endpackage

@@ design/go_to_goal_turn_drive.sv @@
// Go-to-goal turn-or-drive controller: one shared CORDIC, multiplier and divider under a sequencer.
//
// The block keeps a goal position and answers each robot pose with at most one
// motion command (Q16.16 linear speed or angular speed). A goal item sets the
// goal and gives no result. A pose item, while the goal is not reached,
// runs through one sequencer that reuses a single circular vectoring CORDIC
// (one micro-rotation per cycle), a single 44x21 multiplier (product registered)
// and a restoring divider (one quotient bit per cycle). A pose that ends in
// arrival stops at the distance check; a full pose goes on through the
// products, vector scaling (one shift per cycle) and the division.
// s_ready is high only while the sequencer idles; a finished command sits in
// the output register until m_ready takes it.
// Configuration: APB-style, rate_hz at 0x0, arrive_distance at 0x4,
// turn_threshold_deg at 0x8, speed_divisor at 0xC; pready is always high.
module go_to_goal_turn_drive #(
    parameter int CORDIC_ITERATIONS = gtg_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gtg_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output gtg_pkg::out_item_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int ITER_W = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_ITERATIONS - 1);
    localparam int DIV_BITS = 35;

    // sequencer states
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DIFF    = 4'd1;
    localparam logic [3:0] ST_CORDIC  = 4'd2;
    localparam logic [3:0] ST_SCALE0  = 4'd3;
    localparam logic [3:0] ST_SCALE1  = 4'd4;
    localparam logic [3:0] ST_MAC0    = 4'd5;
    localparam logic [3:0] ST_MAC1    = 4'd6;
    localparam logic [3:0] ST_NLOAD   = 4'd7;
    localparam logic [3:0] ST_NSHIFT  = 4'd8;
    localparam logic [3:0] ST_DECIDE  = 4'd9;
    localparam logic [3:0] ST_DIV     = 4'd10;
    localparam logic [3:0] ST_OUT     = 4'd11;

    // what the current CORDIC run is for
    localparam logic [1:0] PH_DIST = 2'd0;
    localparam logic [1:0] PH_CXY  = 2'd1;
    localparam logic [1:0] PH_CZ   = 2'd2;
    localparam logic [1:0] PH_ANG  = 2'd3;

    // product-sum destinations
    localparam logic [3:0] DST_NONE = 4'd0;
    localparam logic [3:0] DST_F0   = 4'd1;
    localparam logic [3:0] DST_F1   = 4'd2;
    localparam logic [3:0] DST_F2   = 4'd3;
    localparam logic [3:0] DST_DOT  = 4'd4;
    localparam logic [3:0] DST_CX   = 4'd5;
    localparam logic [3:0] DST_CY   = 4'd6;
    localparam logic [3:0] DST_CZ   = 4'd7;
    localparam logic [3:0] DST_SIDE = 4'd8;

    localparam logic [4:0] STEP_F_LAST   = 5'd5;
    localparam logic [4:0] STEP_DOT_FIRST = 5'd6;
    localparam logic [4:0] STEP_ALL_LAST = 5'd17;

    localparam logic [35:0] NORM_LO = 36'd1 << 17;
    localparam logic [35:0] NORM_HI = 36'd1 << 18;

    // ---------------------------------------------------------------- registers
    logic [3:0]  state_reg, state_next;
    logic        arrived_reg, arrived_next;
    logic signed [31:0] goal_x_reg, goal_x_next;
    logic signed [31:0] goal_y_reg, goal_y_next;
    logic signed [31:0] goal_z_reg, goal_z_next;
    logic [9:0]  rate_hz_reg, rate_hz_next;
    logic [30:0] arrive_distance_reg, arrive_distance_next;
    logic [7:0]  turn_thr_reg, turn_thr_next;
    logic [7:0]  speed_div_reg, speed_div_next;
    logic        m_valid_reg, m_valid_next;

    gtg_pkg::in_item_t  in_reg, in_next;
    gtg_pkg::out_item_t m_data_reg, m_data_next;
    logic signed [34:0] d_reg [3];
    logic signed [34:0] d_next [3];
    logic signed [34:0] f_reg [3];
    logic signed [34:0] f_next [3];
    logic signed [34:0] nv_reg [3];
    logic signed [34:0] nv_next [3];
    logic [35:0] nm_reg, nm_next;
    logic        nsel_reg, nsel_next;
    logic signed [39:0] acc_reg, acc_next;
    logic signed [39:0] dot_reg, dot_next;
    logic signed [39:0] cx_reg, cx_next;
    logic signed [39:0] cy_reg, cy_next;
    logic signed [39:0] cz_reg, cz_next;
    logic signed [39:0] side_reg, side_next;
    logic signed [64:0] prod_reg, prod_next;
    logic [4:0]  step_reg, step_next;
    logic signed [43:0] x_reg, x_next;
    logic signed [43:0] y_reg, y_next;
    logic signed [27:0] z_reg, z_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic [1:0]  phase_reg, phase_next;
    logic [33:0] dist_reg, dist_next;
    logic [25:0] angle_reg, angle_next;
    logic        turn_reg, turn_next;
    logic        neg_reg, neg_next;
    logic [34:0] dq_reg, dq_next;
    logic [17:0] rem_reg, rem_next;
    logic [17:0] den_reg, den_next;
    logic [5:0]  dcnt_reg, dcnt_next;

    // ---------------------------------------------------------------- helpers
    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] r;
        r = 33'(a) - 33'(b);
        if (r > 33'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (r < -33'sd2147483648)
            return 32'sh80000000;
        return r[31:0];
    endfunction

    function automatic logic [35:0] abs35(input logic signed [34:0] v);
        logic signed [35:0] w;
        w = 36'(v);
        return (w < 0) ? 36'(-w) : 36'(w);
    endfunction

    // ---------------------------------------------------------------- APB
    logic cfg_write;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            gtg_pkg::REG_RATE_HZ:         prdata = {22'd0, rate_hz_reg};
            gtg_pkg::REG_ARRIVE_DISTANCE: prdata = {1'b0, arrive_distance_reg};
            gtg_pkg::REG_TURN_THRESHOLD:  prdata = {24'd0, turn_thr_reg};
            gtg_pkg::REG_SPEED_DIVISOR:   prdata = {24'd0, speed_div_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------- datapath pieces
    // saturated goal difference from the held pose
    logic signed [31:0] dx_w, dy_w, dz_w;
    assign dx_w = sat_sub(goal_x_reg, in_reg.pos_x);
    assign dy_w = sat_sub(goal_y_reg, in_reg.pos_y);
    assign dz_w = sat_sub(goal_z_reg, in_reg.pos_z);

    // one CORDIC micro-rotation
    logic signed [43:0] xs_w, ys_w, x_step, y_step;
    logic signed [27:0] z_step, at_w;
    assign xs_w = x_reg >>> iter_reg;
    assign ys_w = y_reg >>> iter_reg;
    assign at_w = 28'(gtg_pkg::atan_q24(6'(iter_reg)));
    always_comb begin
        if (y_reg < 0) begin
            x_step = x_reg - ys_w;
            y_step = y_reg + xs_w;
            z_step = z_reg - at_w;
        end else begin
            x_step = x_reg + ys_w;
            y_step = y_reg - xs_w;
            z_step = z_reg + at_w;
        end
    end

    // product-sum program: operands per step
    logic signed [43:0] mac_a;
    logic signed [20:0] mac_b;
    logic               mac_sub, mac_first;
    logic [3:0]         mac_dst;
    logic signed [43:0] qa_w, qb_w, qc_w, qd_w;  // w x y z widened for port A
    assign qa_w = 44'(in_reg.quat_w);
    assign qb_w = 44'(in_reg.quat_x);
    assign qc_w = 44'(in_reg.quat_y);
    assign qd_w = 44'(in_reg.quat_z);

    always_comb begin
        mac_a = '0;
        mac_b = '0;
        mac_sub = 1'b0;
        mac_first = 1'b0;
        mac_dst = DST_NONE;
        case (step_reg)
            5'd0:  begin mac_a = qb_w; mac_b = 21'(in_reg.quat_y); mac_first = 1'b1; end
            5'd1:  begin
                mac_a = qa_w; mac_b = 21'(in_reg.quat_z); mac_sub = 1'b1; mac_dst = DST_F0;
            end
            5'd2:  begin
                mac_a = qb_w; mac_b = 21'(in_reg.quat_x); mac_sub = 1'b1; mac_first = 1'b1;
            end
            5'd3:  begin
                mac_a = qd_w; mac_b = 21'(in_reg.quat_z); mac_sub = 1'b1; mac_dst = DST_F1;
            end
            5'd4:  begin mac_a = qc_w; mac_b = 21'(in_reg.quat_z); mac_first = 1'b1; end
            5'd5:  begin mac_a = qa_w; mac_b = 21'(in_reg.quat_x); mac_dst = DST_F2; end
            5'd6:  begin mac_a = 44'(f_reg[0]); mac_b = d_reg[0][20:0]; mac_first = 1'b1; end
            5'd7:  begin mac_a = 44'(f_reg[1]); mac_b = d_reg[1][20:0]; end
            5'd8:  begin mac_a = 44'(f_reg[2]); mac_b = d_reg[2][20:0]; mac_dst = DST_DOT; end
            5'd9:  begin mac_a = 44'(f_reg[1]); mac_b = d_reg[2][20:0]; mac_first = 1'b1; end
            5'd10: begin
                mac_a = 44'(f_reg[2]); mac_b = d_reg[1][20:0]; mac_sub = 1'b1; mac_dst = DST_CX;
            end
            5'd11: begin mac_a = 44'(f_reg[2]); mac_b = d_reg[0][20:0]; mac_first = 1'b1; end
            5'd12: begin
                mac_a = 44'(f_reg[0]); mac_b = d_reg[2][20:0]; mac_sub = 1'b1; mac_dst = DST_CY;
            end
            5'd13: begin mac_a = 44'(f_reg[0]); mac_b = d_reg[1][20:0]; mac_first = 1'b1; end
            5'd14: begin
                mac_a = 44'(f_reg[1]); mac_b = d_reg[0][20:0]; mac_sub = 1'b1; mac_dst = DST_CZ;
            end
            5'd15: begin
                mac_a = 44'(f_reg[1]); mac_b = d_reg[0][20:0]; mac_sub = 1'b1;
                mac_first = 1'b1;
            end
            5'd16: begin mac_a = 44'(f_reg[0]); mac_b = d_reg[1][20:0]; end
            5'd17: begin mac_a = 44'(f_reg[2]); mac_b = d_reg[2][20:0]; mac_dst = DST_SIDE; end
            default: ;
        endcase
    end

    // the one multiplier: product-sum operands, or CORDIC gain correction
    logic signed [43:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [64:0] mul_p;
    assign mul_a = (state_reg == ST_SCALE0) ? x_reg : mac_a;
    assign mul_b = (state_reg == ST_SCALE0) ? $signed({1'b0, gtg_pkg::INVK_Q20}) : mac_b;
    assign mul_p = 65'(mul_a) * 65'(mul_b);

    logic signed [39:0] acc_base, acc_sum;
    assign acc_base = mac_first ? 40'sd0 : acc_reg;
    assign acc_sum  = mac_sub ? (acc_base - prod_reg[39:0]) : (acc_base + prod_reg[39:0]);

    logic signed [39:0] f_wb;
    assign f_wb = (acc_sum <<< 1) + ((mac_dst == DST_F1) ? 40'sd268435456 : 40'sd0);

    // rounded magnitude after gain correction
    logic signed [64:0] mag_full;
    logic signed [43:0] mag_w;
    logic [33:0]        dist_w;
    assign mag_full = (prod_reg + 65'sd524288) >>> 20;
    assign mag_w    = mag_full[43:0];
    assign dist_w   = 34'((mag_w + 44'sd128) >>> 8);

    // vector scaling
    logic signed [34:0] nsrc [3];
    logic [35:0] na0, na1, na2, nmax;
    always_comb begin
        for (int k = 0; k < 3; k++)
            nsrc[k] = nsel_reg ? d_reg[k] : f_reg[k];
    end
    assign na0  = abs35(nsrc[0]);
    assign na1  = abs35(nsrc[1]);
    assign na2  = abs35(nsrc[2]);
    assign nmax = (na0 > na1) ? ((na0 > na2) ? na0 : na2) : ((na1 > na2) ? na1 : na2);

    // turn-or-drive decision
    logic [35:0] ang_lhs, ang_rhs;
    logic        turn_w;
    logic [9:0]  rate1;
    logic [7:0]  div1;
    logic [17:0] q_w;
    logic [34:0] num_w;
    assign ang_lhs = 36'(angle_reg) * 36'd180;
    assign ang_rhs = 36'(turn_thr_reg) * 36'(gtg_pkg::PI_Q24);
    assign turn_w  = ang_lhs > ang_rhs;
    assign rate1   = (rate_hz_reg == 10'd0) ? 10'd1 : rate_hz_reg;
    assign div1    = (speed_div_reg == 8'd0) ? 8'd1 : speed_div_reg;
    assign q_w     = turn_w ? {rate1, 8'd0} : 18'(div1) * 18'(rate1);
    assign num_w   = (turn_w ? 35'(angle_reg) : 35'(dist_reg)) + 35'(q_w >> 1);

    // one restoring-division step
    logic [18:0] rem_sh;
    logic        qbit;
    assign rem_sh = {rem_reg, dq_reg[DIV_BITS-1]};
    assign qbit   = rem_sh >= 19'(den_reg);

    logic signed [26:0] z_clamp_in;
    logic [25:0]        angle_clamped;
    assign z_clamp_in    = z_step[26:0];
    assign angle_clamped = (z_step < 0) ? 26'd0 :
                           (z_step > 28'(gtg_pkg::PI_Q24)) ? gtg_pkg::PI_Q24 : z_clamp_in[25:0];

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        state_next = state_reg;
        arrived_next = arrived_reg;
        goal_x_next = goal_x_reg;
        goal_y_next = goal_y_reg;
        goal_z_next = goal_z_reg;
        rate_hz_next = rate_hz_reg;
        arrive_distance_next = arrive_distance_reg;
        turn_thr_next = turn_thr_reg;
        speed_div_next = speed_div_reg;
        m_valid_next = m_valid_reg && !m_ready;
        in_next = in_reg;
        m_data_next = m_data_reg;
        for (int k = 0; k < 3; k++) begin
            d_next[k] = d_reg[k];
            f_next[k] = f_reg[k];
            nv_next[k] = nv_reg[k];
        end
        nm_next = nm_reg;
        nsel_next = nsel_reg;
        acc_next = acc_reg;
        dot_next = dot_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        side_next = side_reg;
        prod_next = prod_reg;
        step_next = step_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        iter_next = iter_reg;
        phase_next = phase_reg;
        dist_next = dist_reg;
        angle_next = angle_reg;
        turn_next = turn_reg;
        neg_next = neg_reg;
        dq_next = dq_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        dcnt_next = dcnt_reg;

        if (cfg_write) begin
            unique case (paddr[3:2])
                gtg_pkg::REG_RATE_HZ:         rate_hz_next = pwdata[9:0];
                gtg_pkg::REG_ARRIVE_DISTANCE: arrive_distance_next = pwdata[30:0];
                gtg_pkg::REG_TURN_THRESHOLD:  turn_thr_next = pwdata[7:0];
                gtg_pkg::REG_SPEED_DIVISOR:   speed_div_next = pwdata[7:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next = s_data;
                    if (s_data.op) begin
                        goal_x_next = s_data.pos_x;
                        goal_y_next = s_data.pos_y;
                        goal_z_next = s_data.pos_z;
                        arrived_next = 1'b0;
                    end else if (!arrived_reg) begin
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_DIFF: begin
                d_next[0] = 35'(dx_w);
                d_next[1] = 35'(dy_w);
                d_next[2] = 35'(dz_w);
                if (dx_w == 0 && dy_w == 0 && dz_w == 0) begin
                    arrived_next = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    x_next = 44'(abs35(35'(dx_w))) <<< 8;
                    y_next = 44'(dy_w) <<< 8;
                    z_next = '0;
                    iter_next = '0;
                    phase_next = PH_DIST;
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                x_next = x_step;
                y_next = y_step;
                z_next = z_step;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == LAST_ITER) begin
                    if (phase_reg == PH_ANG) begin
                        angle_next = angle_clamped;
                        state_next = ST_DECIDE;
                    end else begin
                        state_next = ST_SCALE0;
                    end
                end
            end
            ST_SCALE0: begin
                prod_next = mul_p;
                state_next = ST_SCALE1;
            end
            ST_SCALE1: begin
                z_next = '0;
                iter_next = '0;
                case (phase_reg)
                    PH_DIST: begin
                        dist_next = dist_w;
                        if (dist_w <= 34'(arrive_distance_reg)) begin
                            arrived_next = 1'b1;
                            state_next = ST_IDLE;
                        end else begin
                            step_next = '0;
                            state_next = ST_MAC0;
                        end
                    end
                    PH_CXY: begin
                        x_next = mag_w;
                        y_next = 44'(cz_reg);
                        phase_next = PH_CZ;
                        state_next = ST_CORDIC;
                    end
                    default: begin
                        // heading: atan2(|f x d|, f.d), folded into the right half-plane
                        if (dot_reg < 0) begin
                            x_next = mag_w;
                            y_next = -44'(dot_reg);
                            z_next = 28'(gtg_pkg::HALF_PI_Q24);
                        end else begin
                            x_next = 44'(dot_reg);
                            y_next = mag_w;
                        end
                        phase_next = PH_ANG;
                        state_next = ST_CORDIC;
                    end
                endcase
            end
            ST_MAC0: begin
                prod_next = mul_p;
                state_next = ST_MAC1;
            end
            ST_MAC1: begin
                acc_next = acc_sum;
                step_next = step_reg + 5'd1;
                state_next = ST_MAC0;
                case (mac_dst)
                    DST_F0:   f_next[0] = f_wb[34:0];
                    DST_F1:   f_next[1] = f_wb[34:0];
                    DST_F2:   f_next[2] = f_wb[34:0];
                    DST_DOT:  dot_next = acc_sum;
                    DST_CX:   cx_next = acc_sum;
                    DST_CY:   cy_next = acc_sum;
                    DST_CZ:   cz_next = acc_sum;
                    DST_SIDE: side_next = acc_sum;
                    default: ;
                endcase
                if (step_reg == STEP_F_LAST) begin
                    nsel_next = 1'b0;
                    state_next = ST_NLOAD;
                end else if (step_reg == STEP_ALL_LAST) begin
                    // cross-product terms need the full accumulator width
                    x_next = (cx_reg < 0) ? -44'(cx_reg) : 44'(cx_reg);
                    y_next = 44'(cy_reg);
                    z_next = '0;
                    iter_next = '0;
                    phase_next = PH_CXY;
                    state_next = ST_CORDIC;
                end
            end
            ST_NLOAD: begin
                for (int k = 0; k < 3; k++)
                    nv_next[k] = nsrc[k];
                nm_next = nmax;
                state_next = ST_NSHIFT;
            end
            ST_NSHIFT: begin
                if (nm_reg != 36'd0 && nm_reg >= NORM_HI) begin
                    nm_next = nm_reg >> 1;
                    for (int k = 0; k < 3; k++)
                        nv_next[k] = nv_reg[k] >>> 1;
                end else if (nm_reg != 36'd0 && nm_reg < NORM_LO) begin
                    nm_next = nm_reg << 1;
                    for (int k = 0; k < 3; k++)
                        nv_next[k] = nv_reg[k] <<< 1;
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        if (nsel_reg)
                            d_next[k] = nv_reg[k];
                        else
                            f_next[k] = nv_reg[k];
                    end
                    if (!nsel_reg) begin
                        nsel_next = 1'b1;
                        state_next = ST_NLOAD;
                    end else if (f_reg[0] == 0 && f_reg[1] == 0 && f_reg[2] == 0) begin
                        // no usable heading: quarter turn to the left
                        angle_next = gtg_pkg::HALF_PI_Q24;
                        side_next = '0;
                        state_next = ST_DECIDE;
                    end else begin
                        step_next = STEP_DOT_FIRST;
                        state_next = ST_MAC0;
                    end
                end
            end
            ST_DECIDE: begin
                turn_next = turn_w;
                neg_next = side_reg > 0;
                den_next = q_w;
                dq_next = num_w;
                rem_next = '0;
                dcnt_next = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = qbit ? 18'(rem_sh - 19'(den_reg)) : rem_sh[17:0];
                dq_next = {dq_reg[DIV_BITS-2:0], qbit};
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'(DIV_BITS - 1))
                    state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    if (turn_reg) begin
                        m_data_next.linear_speed = '0;
                        m_data_next.angular_speed = neg_reg ? -$signed(dq_reg[31:0])
                                                            : $signed(dq_reg[31:0]);
                    end else begin
                        m_data_next.linear_speed = (dq_reg > 35'h7FFFFFFF) ? 32'sh7FFFFFFF
                                                   : $signed(dq_reg[31:0]);
                        m_data_next.angular_speed = '0;
                    end
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state and architectural registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            arrived_reg <= 1'b1;
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            goal_z_reg <= '0;
            rate_hz_reg <= 10'd15;
            arrive_distance_reg <= 31'd6554;
            turn_thr_reg <= 8'd10;
            speed_div_reg <= 8'd10;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            arrived_reg <= arrived_next;
            goal_x_reg <= goal_x_next;
            goal_y_reg <= goal_y_next;
            goal_z_reg <= goal_z_next;
            rate_hz_reg <= rate_hz_next;
            arrive_distance_reg <= arrive_distance_next;
            turn_thr_reg <= turn_thr_next;
            speed_div_reg <= speed_div_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        in_reg <= in_next;
        m_data_reg <= m_data_next;
        for (int k = 0; k < 3; k++) begin
            d_reg[k] <= d_next[k];
            f_reg[k] <= f_next[k];
            nv_reg[k] <= nv_next[k];
        end
        nm_reg <= nm_next;
        nsel_reg <= nsel_next;
        acc_reg <= acc_next;
        dot_reg <= dot_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        cz_reg <= cz_next;
        side_reg <= side_next;
        prod_reg <= prod_next;
        step_reg <= step_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        iter_reg <= iter_next;
        phase_reg <= phase_next;
        dist_reg <= dist_next;
        angle_reg <= angle_next;
        turn_reg <= turn_next;
        neg_reg <= neg_next;
        dq_reg <= dq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        dcnt_reg <= dcnt_next;
    end

endmodule

@@ design/gtg_checker.sv @@
// Port-level checks for the go-to-goal controller, bound to the top level.
module gtg_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input gtg_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input gtg_pkg::out_item_t m_data,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [3:0]         paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready
);

    // a held result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a result only leaves through a handshake
    a_leave: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid) |-> $past(m_ready))
        else $error("result dropped without being taken");

    // a taken item is not turned into a result at once
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !(m_valid && !$past(m_valid)))
        else $error("result too soon after an item");

    // a rate write reads back on the following cycle
    a_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready && paddr[3:2] == gtg_pkg::REG_RATE_HZ)
        ##1 (paddr[3:2] == gtg_pkg::REG_RATE_HZ && !pwrite)
        |-> prdata[9:0] == $past(pwdata[9:0]))
        else $error("rate register read-back mismatch");

endmodule

bind go_to_goal_turn_drive gtg_checker u_gtg_checker (.*);
